FILE: rtl/brsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brsc_pkg
// Shared types and codes for the bitmap range set/clear block.
// ----------------------------------------------------------------------------
package brsc_pkg;

  // request action codes
  localparam logic [1:0] ACT_SET   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_CHECK = 2'd2;

  // bits per map word and its index width
  localparam int WORD_BITS = 64;
  localparam int POS_W     = 6;

  // request beat
  typedef struct packed {
    logic [1:0]  action;
    logic [11:0] start_bit;
    logic [12:0] run_length;
  } req_t;

  // response beat
  typedef struct packed {
    logic bit_is_set;
    logic clipped;
  } rsp_t;

  // controller states
  typedef enum logic [2:0] {
    ST_WIPE,
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_MODIFY,
    ST_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic wipe;
    logic mem_rd;
    logic mem_wr;
    logic step;
    logic res_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic wipe_done;
    logic range_work;
    logic check_hit;
    logic walk_last;
  } stat_t;

endpackage
`default_nettype wire

FILE: rtl/bitmap_range_set_clear_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_range_set_clear_top
// Allocation bitmap with range set/clear and single-bit check requests.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall/req) carries one request beat: action,
//   start bit and run length. rsp channel (rsp_valid/rsp_stall/rsp) returns
//   exactly one beat per request: bit_is_set and clipped.
//   One request is in flight at a time. Each map word touched by a range
//   is read and then written back on the single bitmap memory port; a
//   check reads its one word, and an empty, unused or out-of-map request
//   goes from decode straight to loading the response. The response is
//   registered and appears on rsp in the cycle after loading.
//   After reset a clearing pass zeroes the map, one word per cycle, and
//   req_stall stays high during it. The response sits in an output
//   register; while an earlier response beat is still stalled, the finished
//   request waits in its last step and the next request is held off until
//   that beat is taken.
// ----------------------------------------------------------------------------
module bitmap_range_set_clear_top #(
  parameter int MAP_WORDS = 64
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             req_valid,
  output logic            req_stall,
  input  brsc_pkg::req_t  req,
  output logic            rsp_valid,
  input  wire             rsp_stall,
  output brsc_pkg::rsp_t  rsp
);
  import brsc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  brsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // memory and mask datapath
  brsc_datapath #(
    .MAP_WORDS (MAP_WORDS)
  ) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule
`default_nettype wire

FILE: rtl/brsc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brsc_datapath
// Bitmap memory, request registers, word walk counter and mask logic.
// ----------------------------------------------------------------------------
module brsc_datapath #(
  parameter int MAP_WORDS = 64
) (
  input  wire              clk,
  input  wire              rst,
  input  brsc_pkg::req_t   req,
  input  brsc_pkg::cmd_t   cmd,
  output brsc_pkg::stat_t  stat,
  output brsc_pkg::rsp_t   rsp
);
  import brsc_pkg::*;

  localparam int          AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int          CW    = (AW > 8) ? AW : 8;
  localparam int unsigned NBITS = MAP_WORDS * WORD_BITS;

  logic [WORD_BITS-1:0] mem [MAP_WORDS];

  req_t                 cur;
  logic [CW-1:0]        word;
  logic [WORD_BITS-1:0] rd_data;

  logic [13:0]          end_raw;
  logic                 clip;
  logic [13:0]          end_clip;
  logic [13:0]          end_m1;
  logic [CW-1:0]        first_word;
  logic [CW-1:0]        last_word;
  logic                 is_range;
  logic                 in_map;
  logic [AW-1:0]        addr;
  logic [WORD_BITS-1:0] head_mask;
  logic [WORD_BITS-1:0] tail_mask;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] wr_data;
  logic                 res_bit;
  logic                 res_clip;

  // run bounds, clipped to the map end
  assign end_raw    = 14'(cur.start_bit) + 14'(cur.run_length);
  assign clip       = (cur.run_length != '0) && (32'(end_raw) > NBITS);
  assign end_clip   = clip ? 14'(NBITS) : end_raw;
  assign end_m1     = end_clip - 14'd1;
  assign first_word = CW'(cur.start_bit[11:POS_W]);
  assign last_word  = CW'(end_m1[13:POS_W]);
  assign is_range   = (cur.action == ACT_SET) || (cur.action == ACT_CLEAR);
  assign in_map     = 32'(cur.start_bit[11:POS_W]) < MAP_WORDS;

  // status to the controller
  assign stat.wipe_done  = (word == CW'(MAP_WORDS - 1));
  assign stat.range_work = is_range && (cur.run_length != '0) &&
                           (14'(cur.start_bit) < end_clip);
  assign stat.check_hit  = (cur.action == ACT_CHECK) && in_map;
  assign stat.walk_last  = (word == last_word);

  // head and tail masks for the current word
  assign head_mask = (word == first_word) ?
                     ({WORD_BITS{1'b1}} << cur.start_bit[POS_W-1:0]) :
                     {WORD_BITS{1'b1}};
  assign tail_mask = stat.walk_last ?
                     ({WORD_BITS{1'b1}} >> (6'd63 - end_m1[POS_W-1:0])) :
                     {WORD_BITS{1'b1}};
  assign mask      = head_mask & tail_mask;

  // write data: wipe, set or clear
  always_comb begin
    if (cmd.wipe) begin
      wr_data = '0;
    end else if (cur.action == ACT_SET) begin
      wr_data = rd_data | mask;
    end else begin
      wr_data = rd_data & ~mask;
    end
  end

  assign addr = AW'(word);

  // request capture and word walk counter
  always_ff @(posedge clk) begin
    if (rst) begin
      word <= '0;
    end else if (cmd.load) begin
      word <= CW'(req.start_bit[11:POS_W]);
    end else if (cmd.step) begin
      word <= word + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= req;
    end
  end

  // bitmap memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[addr] <= wr_data;
    end
    if (cmd.mem_rd) begin
      rd_data <= mem[addr];
    end
  end

  // response fields
  always_comb begin
    res_bit  = 1'b0;
    res_clip = 1'b0;
    if (is_range) begin
      res_clip = clip;
    end else if (cur.action == ACT_CHECK) begin
      res_bit  = in_map && rd_data[cur.start_bit[POS_W-1:0]];
      res_clip = !in_map;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      rsp.bit_is_set <= res_bit;
      rsp.clipped    <= res_clip;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/brsc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brsc_ctrl
// Sequencer: clearing pass, request decode, read-modify-write walk, response.
// ----------------------------------------------------------------------------
module brsc_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              req_valid,
  output logic             req_stall,
  output logic             rsp_valid,
  input  wire              rsp_stall,
  input  brsc_pkg::stat_t  stat,
  output brsc_pkg::cmd_t   cmd
);
  import brsc_pkg::*;

  state_t state;
  state_t state_next;
  logic   rsp_free;

  assign rsp_free = !rsp_valid || !rsp_stall;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_WIPE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_WIPE: begin
        if (stat.wipe_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        if (stat.range_work || stat.check_hit) begin
          state_next = ST_READ;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_READ: begin
        state_next = stat.range_work ? ST_MODIFY : ST_FINISH;
      end
      ST_MODIFY: begin
        state_next = stat.walk_last ? ST_FINISH : ST_READ;
      end
      ST_FINISH: begin
        if (rsp_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    req_stall = 1'b1;
    case (state)
      ST_WIPE: begin
        cmd.wipe   = 1'b1;
        cmd.mem_wr = 1'b1;
        cmd.step   = !stat.wipe_done;
      end
      ST_IDLE: begin
        req_stall = 1'b0;
        cmd.load  = req_valid;
      end
      ST_READ: begin
        cmd.mem_rd = 1'b1;
      end
      ST_MODIFY: begin
        cmd.mem_wr = 1'b1;
        cmd.step   = 1'b1;
      end
      ST_FINISH: begin
        cmd.res_load = rsp_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // response valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.res_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_rd_wr_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.mem_rd && cmd.mem_wr))
    else $error("memory read and write in the same cycle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> (!rsp_valid || !rsp_stall))
    else $error("response loaded over a stalled beat");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(cmd.res_load))
    else $error("response valid without a result load");

  a_wipe_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WIPE && stat.wipe_done) |=> (state == ST_IDLE))
    else $error("clearing pass did not end in idle");
`endif

endmodule
`default_nettype wire

FILE: tb/bitmap_range_set_clear_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_range_set_clear_top_test
// Self-checking bench for the allocation bitmap block. A bit-level shadow
// map predicts every response as its request beat is accepted. A directed
// pass covers the corner cases: zero length, word-crossing runs, upper word
// halves, clipping and the unused action. Random passes follow with the
// sender idling, the receiver stalling, both, or neither.
// ----------------------------------------------------------------------------
module bitmap_range_set_clear_top_test;
  import brsc_pkg::*;

  localparam int MAP_WORDS = 64;
  localparam int MAP_BITS = MAP_WORDS * WORD_BITS;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  // longest range request plus margin
  localparam int TAIL_CYCLES = 3 + 2 * MAP_WORDS + 20;
  localparam int QUIET_LIMIT = 2000;
  localparam int REPORT_CAP = 40;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  // shadow of the map, bit b lives in word b/64 at position b%64
  logic [MAP_BITS-1:0] shadow_map;
  rsp_t pending_rsp_q[$];
  int unsigned error_count;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned quiet_cycles = 0;

  bitmap_range_set_clear_top #(
    .MAP_WORDS(MAP_WORDS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // update the shadow map and work out the response for one request
  task automatic apply_to_shadow(input req_t r, output rsp_t want);
    int unsigned first;
    int unsigned stop;
    logic fill;
    first = r.start_bit;
    stop = first + r.run_length;
    want = '0;
    case (r.action)
      ACT_SET, ACT_CLEAR: begin
        fill = (r.action == ACT_SET);
        if (r.run_length != 0) begin
          if (stop > MAP_BITS) begin
            want.clipped = 1'b1;
            stop = MAP_BITS;
          end
          for (int unsigned b = first; b < stop; b++) shadow_map[b] = fill;
        end
      end
      ACT_CHECK: begin
        if (first < MAP_BITS) want.bit_is_set = shadow_map[first];
        else want.clipped = 1'b1;
      end
      default: ;
    endcase
  endtask

  // drive one request beat; entered and left at a falling edge
  task automatic send_request(input logic [1:0] action, input int unsigned start_bit,
                              input int unsigned run_length);
    req_t beat;
    rsp_t want;
    beat.action = action;
    beat.start_bit = 12'(start_bit);
    beat.run_length = 13'(run_length);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_valid = 1'b1;
    req = beat;
    do @(posedge clk); while (req_stall);
    apply_to_shadow(beat, want);
    pending_rsp_q.push_back(want);
    @(negedge clk);
  endtask

  // hold off the sender until every response is back
  task automatic wait_drained();
    req_valid = 1'b0;
    while (pending_rsp_q.size() != 0) @(negedge clk);
  endtask

  // mostly short runs, some long, a few past the map end
  function automatic int unsigned pick_run_length();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) return $urandom_range(130);
    if (roll < 90) return $urandom_range(600);
    return $urandom_range(8191);
  endfunction

  task automatic send_random_request();
    int unsigned roll;
    logic [1:0] action;
    roll = $urandom_range(99);
    if (roll < 35) action = ACT_SET;
    else if (roll < 63) action = ACT_CLEAR;
    else if (roll < 95) action = ACT_CHECK;
    else action = ACT_UNUSED;
    send_request(action, $urandom_range(MAP_BITS - 1), pick_run_length());
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(99) < stall_pct);
  end

  // compare each response beat with the oldest prediction
  always @(posedge clk) begin : check_rsp
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp_q.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_CAP)
          $display("%0t: response beat with none expected, actual bit_is_set %0b clipped %0b",
                   $time, rsp.bit_is_set, rsp.clipped);
      end else begin
        want = pending_rsp_q.pop_front();
        if (rsp.bit_is_set !== want.bit_is_set) begin
          error_count++;
          if (error_count <= REPORT_CAP)
            $display("%0t: bit_is_set mismatch, expected %0b actual %0b",
                     $time, want.bit_is_set, rsp.bit_is_set);
        end
        if (rsp.clipped !== want.clipped) begin
          error_count++;
          if (error_count <= REPORT_CAP)
            $display("%0t: clipped mismatch, expected %0b actual %0b",
                     $time, want.clipped, rsp.clipped);
        end
      end
    end
  end

  // watchdog: no beat moving on either channel for too long
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // corner cases with no idling
  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct = 0;
    send_request(ACT_SET, 0, 0);
    send_request(ACT_CHECK, 0, 0);
    send_request(ACT_SET, 0, 1);
    send_request(ACT_CHECK, 0, 8191);
    // upper half of a word
    send_request(ACT_SET, 32, 32);
    send_request(ACT_CHECK, 63, 0);
    send_request(ACT_CHECK, 31, 0);
    // head mask, full words, tail mask
    send_request(ACT_SET, 60, 200);
    send_request(ACT_CHECK, 128, 0);
    send_request(ACT_CHECK, 260, 0);
    send_request(ACT_CLEAR, 62, 3);
    send_request(ACT_CHECK, 64, 0);
    send_request(ACT_CHECK, 65, 0);
    // runs past the map end
    send_request(ACT_SET, 4000, 200);
    send_request(ACT_CHECK, 4095, 0);
    send_request(ACT_CLEAR, 4095, 8191);
    send_request(ACT_CHECK, 4095, 0);
    // whole map, exact fit
    send_request(ACT_SET, 0, MAP_BITS);
    send_request(ACT_CHECK, 2047, 0);
    send_request(ACT_CLEAR, 2048, 0);
    send_request(ACT_UNUSED, 4095, 8191);
    send_request(ACT_CLEAR, 0, 8191);
    send_request(ACT_CHECK, 4095, 0);
    send_request(ACT_SET, 4095, 1);
    send_request(ACT_CHECK, 4095, 0);
  endtask

  task automatic test_random_phase(input int unsigned idle_pct, input int unsigned hold_pct,
                                   input int unsigned count);
    send_idle_pct = idle_pct;
    stall_pct = hold_pct;
    repeat (count) send_random_request();
  endtask

  // sender stops until the block has answered everything
  task automatic test_pause_until_drained();
    send_idle_pct = 0;
    stall_pct = 34;
    repeat (2) begin
      repeat (8) send_random_request();
      wait_drained();
    end
    repeat (8) send_random_request();
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_stall = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    error_count = 0;
    shadow_map = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random_phase(0, 0, 90);
    test_pause_until_drained();
    test_random_phase(52, 0, 90);
    test_random_phase(0, 52, 90);
    test_random_phase(34, 34, 90);

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
